@@ rtl/uhd_pkg.sv @@
// Types and constants shared by the underfill hysteresis detector modules.
`default_nettype none

package uhd_pkg;

    // Field widths of one input word and of the configuration registers.
    localparam int FILES_W   = 20;
    localparam int BYTES_W   = 48;
    localparam int PCT_W     = 7;
    localparam int SAMPLE_W  = 16;
    localparam int ELAPSED_W = 20;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam int OUTCOME_W = 3;

    // Product widths of the fill comparisons.
    localparam int PROD_F_W = FILES_W + PCT_W;
    localparam int PROD_B_W = BYTES_W + PCT_W;

    // A full request expressed as a percentage.
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX  = 16'hFFFF;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 20'hFFFFF;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WATCH_PERIOD = 2'd0,
        REG_MIN_SAMPLES  = 2'd1,
        REG_START_PCT    = 2'd2,
        REG_RECOVERY_PCT = 2'd3
    } cfg_reg_t;

    // Kind of an input word as decided by the front end.
    typedef enum logic [1:0] {
        KIND_TICK      = 2'd0,
        KIND_IGNORE    = 2'd1,
        KIND_MALFORMED = 2'd2,
        KIND_RESPONSE  = 2'd3
    } item_kind_t;

    // Result codes.
    typedef enum logic [OUTCOME_W-1:0] {
        OUT_NONE      = 3'd0,
        OUT_STARTED   = 3'd1,
        OUT_RECOVERED = 3'd2,
        OUT_STILL     = 3'd3,
        OUT_DISMOUNT  = 3'd4,
        OUT_MALFORMED = 3'd5
    } outcome_t;

    // Classified word handed from the front end to the back end.
    typedef struct packed {
        item_kind_t kind;
        logic       meets_start;
        logic       meets_recovery;
    } item_cls_t;

endpackage

`default_nettype wire

@@ rtl/uhd_front.sv @@
// Front end: accepts input words, forms the fill products and classifies each word.
`default_nettype none

module uhd_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          in_func,
    input  wire logic                          in_end_marker,
    input  wire logic [uhd_pkg::FILES_W-1:0]   in_files_fetched,
    input  wire logic [uhd_pkg::BYTES_W-1:0]   in_bytes_fetched,
    input  wire logic [uhd_pkg::FILES_W-1:0]   in_files_wanted,
    input  wire logic [uhd_pkg::BYTES_W-1:0]   in_bytes_wanted,
    input  wire logic [uhd_pkg::PCT_W-1:0]     start_pct,
    input  wire logic [uhd_pkg::PCT_W-1:0]     recovery_pct,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output uhd_pkg::item_cls_t                 out_cls
);

    localparam int PF = uhd_pkg::PROD_F_W;
    localparam int PB = uhd_pkg::PROD_B_W;

    logic          st_valid_reg;
    logic          func_reg;
    logic          end_reg;
    logic          fw_zero_reg;
    logic          bw_zero_reg;
    logic [PF-1:0] ff100_reg;
    logic [PB-1:0] bf100_reg;
    logic [PF-1:0] fw_start_reg;
    logic [PB-1:0] bw_start_reg;
    logic [PF-1:0] fw_rec_reg;
    logic [PB-1:0] bw_rec_reg;
    logic          accept;
    logic          meets_start;
    logic          meets_rec;

    // The product stage takes a new word when it is empty or its word moves on.
    assign in_ready = !st_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (accept) begin
            st_valid_reg <= 1'b1;
        end else if (out_ready) begin
            st_valid_reg <= 1'b0;
        end
    end

    // Fetched counts times one hundred, and each threshold times the limits.
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg     <= in_func;
            end_reg      <= in_end_marker;
            fw_zero_reg  <= (in_files_wanted == '0);
            bw_zero_reg  <= (in_bytes_wanted == '0);
            ff100_reg    <= PF'(in_files_fetched) * PF'(uhd_pkg::PCT_FULL);
            bf100_reg    <= PB'(in_bytes_fetched) * PB'(uhd_pkg::PCT_FULL);
            fw_start_reg <= PF'(start_pct) * PF'(in_files_wanted);
            bw_start_reg <= PB'(start_pct) * PB'(in_bytes_wanted);
            fw_rec_reg   <= PF'(recovery_pct) * PF'(in_files_wanted);
            bw_rec_reg   <= PB'(recovery_pct) * PB'(in_bytes_wanted);
        end
    end

    // Fill meets a threshold if either capped ratio does; above 100 % it never does,
    // and a zero limit gives a ratio of nought.
    always_comb begin
        logic f_start;
        logic b_start;
        logic f_rec;
        logic b_rec;
        f_start = fw_zero_reg ? (start_pct == '0) : (ff100_reg >= fw_start_reg);
        b_start = bw_zero_reg ? (start_pct == '0) : (bf100_reg >= bw_start_reg);
        f_rec   = fw_zero_reg ? (recovery_pct == '0) : (ff100_reg >= fw_rec_reg);
        b_rec   = bw_zero_reg ? (recovery_pct == '0) : (bf100_reg >= bw_rec_reg);
        meets_start = (start_pct <= uhd_pkg::PCT_FULL) && (f_start || b_start);
        meets_rec   = (recovery_pct <= uhd_pkg::PCT_FULL) && (f_rec || b_rec);
    end

    // Word kind, ticks taking precedence over the sentinel and malformed checks.
    always_comb begin
        out_cls.meets_start    = meets_start;
        out_cls.meets_recovery = meets_rec;
        if (func_reg) begin
            out_cls.kind = uhd_pkg::KIND_TICK;
        end else if (end_reg) begin
            out_cls.kind = uhd_pkg::KIND_IGNORE;
        end else if (fw_zero_reg && bw_zero_reg) begin
            out_cls.kind = uhd_pkg::KIND_MALFORMED;
        end else begin
            out_cls.kind = uhd_pkg::KIND_RESPONSE;
        end
    end

    assign out_valid = st_valid_reg;

endmodule

`default_nettype wire

@@ rtl/uhd_fifo.sv @@
// Small register queue between the front end and the back end.
`default_nettype none

module uhd_fifo #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Storage is written at the tail only.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    // Pointers wrap at the depth; the count tracks occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/uhd_back.sv @@
// Back end: period state, sample and elapsed-time counters, and the result register.
`default_nettype none

module uhd_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire uhd_pkg::item_cls_t              in_cls,
    input  wire logic [uhd_pkg::ELAPSED_W-1:0]   watch_period_secs,
    input  wire logic [uhd_pkg::SAMPLE_W-1:0]    min_samples,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 out_dismount,
    output logic                                 out_period_active,
    output logic [uhd_pkg::SAMPLE_W-1:0]         out_sample_total,
    output uhd_pkg::outcome_t                    out_outcome
);

    logic                            active_reg;
    logic                            active_next;
    logic [uhd_pkg::SAMPLE_W-1:0]    sample_reg;
    logic [uhd_pkg::SAMPLE_W-1:0]    sample_next;
    logic [uhd_pkg::ELAPSED_W-1:0]   elapsed_reg;
    logic [uhd_pkg::ELAPSED_W-1:0]   elapsed_next;
    uhd_pkg::outcome_t               outcome_next;
    logic                            dismount_next;
    logic                            out_valid_reg;
    logic                            dismount_reg;
    logic                            active_out_reg;
    logic [uhd_pkg::SAMPLE_W-1:0]    sample_out_reg;
    uhd_pkg::outcome_t               outcome_reg;
    logic                            pop;

    // A word is taken whenever the result register is empty or being emptied.
    assign in_ready = !out_valid_reg || out_ready;
    assign pop      = in_valid && in_ready;

    // State update for one classified word.
    always_comb begin
        active_next   = active_reg;
        sample_next   = sample_reg;
        elapsed_next  = elapsed_reg;
        outcome_next  = uhd_pkg::OUT_NONE;
        dismount_next = 1'b0;
        case (in_cls.kind)
            uhd_pkg::KIND_TICK: begin
                if (active_reg && (elapsed_reg != uhd_pkg::ELAPSED_MAX)) begin
                    elapsed_next = elapsed_reg + 1'b1;
                end
            end
            uhd_pkg::KIND_MALFORMED: begin
                outcome_next = uhd_pkg::OUT_MALFORMED;
            end
            uhd_pkg::KIND_RESPONSE: begin
                if (!active_reg) begin
                    if (!in_cls.meets_start) begin
                        active_next  = 1'b1;
                        sample_next  = uhd_pkg::SAMPLE_W'(1);
                        elapsed_next = '0;
                        outcome_next = uhd_pkg::OUT_STARTED;
                    end
                end else if (in_cls.meets_recovery) begin
                    active_next  = 1'b0;
                    sample_next  = '0;
                    elapsed_next = '0;
                    outcome_next = uhd_pkg::OUT_RECOVERED;
                end else begin
                    if (sample_reg != uhd_pkg::SAMPLE_MAX) begin
                        sample_next = sample_reg + 1'b1;
                    end
                    if ((elapsed_reg >= watch_period_secs) && (sample_next >= min_samples)) begin
                        dismount_next = 1'b1;
                        outcome_next  = uhd_pkg::OUT_DISMOUNT;
                    end else begin
                        outcome_next = uhd_pkg::OUT_STILL;
                    end
                end
            end
            default: begin
                outcome_next = uhd_pkg::OUT_NONE;
            end
        endcase
    end

    // Period state and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            sample_reg    <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                active_reg  <= active_next;
                sample_reg  <= sample_next;
                elapsed_reg <= elapsed_next;
            end
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result word payload.
    always_ff @(posedge aclk) begin
        if (pop) begin
            dismount_reg   <= dismount_next;
            active_out_reg <= active_next;
            sample_out_reg <= sample_next;
            outcome_reg    <= outcome_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_dismount      = dismount_reg;
    assign out_period_active = active_out_reg;
    assign out_sample_total  = sample_out_reg;
    assign out_outcome       = outcome_reg;

endmodule

`default_nettype wire

@@ rtl/underfill_hysteresis_detector.sv @@
// Top level of the underfill hysteresis detector: configuration registers and wiring.
// One input word is taken every clock cycle while the result side keeps up; each word
// gives exactly one result word. A word passes through the product stage of the front end
// and then the queue, after which the back end loads its result register, which offers the
// result word on the result port. While the result side is stalled, up to QUEUE_DEPTH + 2
// words (product stage, queue and result register) are held before the input side stops
// taking words. The queue-end sentinel travels as s_tlast. Configuration registers are
// written through a plain write port and must only change while no word is in flight.
`default_nettype none

module underfill_hysteresis_detector #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input words.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // files_fetched[19:0], bytes_fetched[67:20], files_wanted[87:68], bytes_wanted[135:88]
    input  wire logic [135:0]                    s_tdata,
    // func[0]
    input  wire logic [0:0]                      s_tuser,
    // end_marker
    input  wire logic                            s_tlast,
    // Result words.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // dismount[0], period_active[1], sample_total[17:2], zero fill[23:18]
    output logic [23:0]                          m_tdata,
    // outcome[2:0]
    output logic [2:0]                           m_tuser,
    // Configuration write port.
    input  wire logic                            cfg_wr_en,
    input  wire logic [uhd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [uhd_pkg::CFG_W-1:0]       cfg_data
);

    logic [uhd_pkg::ELAPSED_W-1:0] watch_period_reg;
    logic [uhd_pkg::SAMPLE_W-1:0]  min_samples_reg;
    logic [uhd_pkg::PCT_W-1:0]     start_pct_reg;
    logic [uhd_pkg::PCT_W-1:0]     recovery_pct_reg;

    logic                          front_valid;
    logic                          front_ready;
    uhd_pkg::item_cls_t            front_cls;
    logic                          back_valid;
    logic                          back_ready;
    logic [$bits(uhd_pkg::item_cls_t)-1:0] queue_in;
    logic [$bits(uhd_pkg::item_cls_t)-1:0] queue_out;

    logic                          res_dismount;
    logic                          res_active;
    logic [uhd_pkg::SAMPLE_W-1:0]  res_samples;
    uhd_pkg::outcome_t             res_outcome;

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            watch_period_reg <= '0;
            min_samples_reg  <= '0;
            start_pct_reg    <= '0;
            recovery_pct_reg <= '0;
        end else if (cfg_wr_en) begin
            case (uhd_pkg::cfg_reg_t'(cfg_index))
                uhd_pkg::REG_WATCH_PERIOD: watch_period_reg <= cfg_data;
                uhd_pkg::REG_MIN_SAMPLES:  min_samples_reg  <= cfg_data[uhd_pkg::SAMPLE_W-1:0];
                uhd_pkg::REG_START_PCT:    start_pct_reg    <= cfg_data[uhd_pkg::PCT_W-1:0];
                uhd_pkg::REG_RECOVERY_PCT: recovery_pct_reg <= cfg_data[uhd_pkg::PCT_W-1:0];
                default: begin
                    watch_period_reg <= watch_period_reg;
                end
            endcase
        end
    end

    uhd_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_func          (s_tuser[0]),
        .in_end_marker    (s_tlast),
        .in_files_fetched (s_tdata[19:0]),
        .in_bytes_fetched (s_tdata[67:20]),
        .in_files_wanted  (s_tdata[87:68]),
        .in_bytes_wanted  (s_tdata[135:88]),
        .start_pct        (start_pct_reg),
        .recovery_pct     (recovery_pct_reg),
        .out_valid        (front_valid),
        .out_ready        (front_ready),
        .out_cls          (front_cls)
    );

    assign queue_in = front_cls;

    uhd_fifo #(
        .WIDTH ($bits(uhd_pkg::item_cls_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (queue_in),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_data  (queue_out)
    );

    uhd_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (back_valid),
        .in_ready          (back_ready),
        .in_cls            (uhd_pkg::item_cls_t'(queue_out)),
        .watch_period_secs (watch_period_reg),
        .min_samples       (min_samples_reg),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_dismount      (res_dismount),
        .out_period_active (res_active),
        .out_sample_total  (res_samples),
        .out_outcome       (res_outcome)
    );

    // Pack the result word.
    assign m_tdata = {6'b0, res_samples, res_active, res_dismount};
    assign m_tuser = res_outcome;

endmodule

`default_nettype wire
